// ===== sv/sha1md_pkg.sv =====
// Shared types, constants and a helper function of the SHA-1 message digest block.
package sha1md_pkg;

  localparam int WORD_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int POS_W        = 6;
  localparam int COUNT_W      = 61;
  localparam int ROUND_W      = 7;
  localparam int NUM_ROUNDS   = 80;
  localparam int SCHED_DEPTH  = 16;
  localparam int DIGEST_WORDS = 5;
  localparam int INDEX_W      = 3;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [ROUND_W-1:0] round_t;

  // Working variables a..e of the compression.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } vars_t;

  // Round counts at which the round function and constant change.
  localparam round_t PHASE1_START = round_t'(20);
  localparam round_t PHASE2_START = round_t'(40);
  localparam round_t PHASE3_START = round_t'(60);
  localparam round_t ROUND_LAST   = round_t'(NUM_ROUNDS - 1);

  localparam word_t K_PHASE0 = 32'h5A827999;
  localparam word_t K_PHASE1 = 32'h6ED9EBA1;
  localparam word_t K_PHASE2 = 32'h8F1BBCDC;
  localparam word_t K_PHASE3 = 32'hCA62C1D6;

  localparam word_t H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam byte_t PAD_MARK = 8'h80;

  function automatic word_t rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

// ===== sv/sha1_message_digest.sv =====
// Top level of the streaming SHA-1 message digest block.
//
// The block hashes a byte stream with SHA-1. Each input beat carries at most
// one message byte (byte_present) and an end-of-message mark, so a bare end
// mark closes a message, and closes an empty message when no byte came
// before it. The beat that completes a 64-byte block starts the
// compression, which runs one round per cycle through a single shared
// round unit and then adds the result into the chaining words; item_stall
// is high through the rounds and the add, and also while padding and
// while the digest is offered, so no byte is taken then. At the end mark
// the sequencer feeds the padding through the same byte path, one pad
// byte per cycle while no compression runs
// (0x80, zeros, then the 64-bit bit length), with one or two further
// compressions, and then offers the five digest words as five result beats,
// word 0 first, the last one flagged by last_word. No new input is taken
// until the fifth word has been taken; the chaining words then return to
// the SHA-1 initial values. There is no clearing pass after reset.
module sha1_message_digest (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  sha1md_pkg::byte_t                    data_byte,
  input  logic                                 byte_present,
  input  logic                                 end_of_message,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output sha1md_pkg::word_t                    digest_word,
  output logic [sha1md_pkg::INDEX_W-1:0]       word_index,
  output logic                                 last_word
);

  typedef enum logic [2:0] {
    S_GATHER,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  // Where the sequencer goes once a compression has been added in.
  typedef enum logic [1:0] {
    A_GATHER,
    A_PAD,
    A_OUT
  } after_t;

  state_t state;
  after_t after;

  sha1md_pkg::word_t  chain [sha1md_pkg::DIGEST_WORDS];
  sha1md_pkg::word_t  sched [sha1md_pkg::SCHED_DEPTH];
  sha1md_pkg::vars_t  vars;
  sha1md_pkg::vars_t  vars_next;
  sha1md_pkg::round_t round;

  logic [sha1md_pkg::POS_W-1:0]   pos;
  logic [sha1md_pkg::COUNT_W-1:0] count;
  logic [23:0]                    word_acc;
  logic                           pad_first;
  logic                           len_phase;

  logic                           accept;
  logic                           absorb_en;
  sha1md_pkg::byte_t              absorb_byte;
  sha1md_pkg::byte_t              pad_byte;
  sha1md_pkg::byte_t              len_byte;
  logic [63:0]                    bit_length;
  logic                           word_done;
  logic                           block_done;
  logic                           len_start;
  sha1md_pkg::word_t              sched_expand;
  sha1md_pkg::vars_t              chain_vars;

  assign item_stall = (state != S_GATHER);
  assign accept     = item_valid && !item_stall;

  // The bit length is the byte count times eight; its bytes go out most
  // significant first while the block position runs from 56 to 63.
  assign bit_length = {count, 3'b000};
  assign len_byte   = sha1md_pkg::byte_t'(bit_length >> {~pos[2:0], 3'b000});

  // The length starts at position 56 of the block in which the zero fill
  // reaches that position, never on the marker byte itself.
  assign len_start = !pad_first && (pos == sha1md_pkg::POS_W'(56));

  always_comb begin
    priority if (pad_first) begin
      pad_byte = sha1md_pkg::PAD_MARK;
    end else if (len_start || len_phase) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = '0;
    end
  end

  assign absorb_en   = (accept && byte_present) || (state == S_PAD);
  assign absorb_byte = (state == S_PAD) ? pad_byte : data_byte;
  assign word_done   = (pos[1:0] == 2'b11);
  assign block_done  = (pos == '1);

  assign chain_vars = '{a: chain[0], b: chain[1], c: chain[2], d: chain[3], e: chain[4]};

  // Message schedule as a 16-word shift line: sched[0] is the word of the
  // current round, and the expanded word enters at the far end.
  assign sched_expand = sha1md_pkg::rotl(sched[13] ^ sched[8] ^ sched[2] ^ sched[0], 1);

  sha1md_round u_round (
    .vars        (vars),
    .sched_word  (sched[0]),
    .round_index (round),
    .advanced    (vars_next)
  );

  always_ff @(posedge clk) begin
    if (absorb_en) begin
      word_acc <= {word_acc[15:0], absorb_byte};
    end
    if ((absorb_en && word_done) || (state == S_ROUND)) begin
      for (int i = 0; i < sha1md_pkg::SCHED_DEPTH - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[sha1md_pkg::SCHED_DEPTH-1] <= (state == S_ROUND) ? sched_expand
                                                            : {word_acc, absorb_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_GATHER;
      after        <= A_GATHER;
      pos          <= '0;
      count        <= '0;
      round        <= '0;
      pad_first    <= 1'b0;
      len_phase    <= 1'b0;
      result_valid <= 1'b0;
      word_index   <= '0;
      for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
        chain[i] <= sha1md_pkg::H_INIT[i];
      end
    end else begin
      unique case (state)
        S_GATHER: begin
          if (accept) begin
            if (byte_present) begin
              count <= count + 1'b1;
              pos   <= pos + 1'b1;
              if (block_done) begin
                vars  <= chain_vars;
                round <= '0;
                after <= end_of_message ? A_PAD : A_GATHER;
                state <= S_ROUND;
              end
            end
            if (end_of_message) begin
              pad_first <= 1'b1;
              if (!(byte_present && block_done)) begin
                state <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          pos       <= pos + 1'b1;
          pad_first <= 1'b0;
          if (len_start) begin
            len_phase <= 1'b1;
          end
          if (block_done) begin
            vars      <= chain_vars;
            round     <= '0;
            after     <= len_phase ? A_OUT : A_PAD;
            len_phase <= 1'b0;
            state     <= S_ROUND;
          end
        end
        S_ROUND: begin
          vars <= vars_next;
          if (round == sha1md_pkg::ROUND_LAST) begin
            round <= '0;
            state <= S_ADD;
          end else begin
            round <= round + 1'b1;
          end
        end
        S_ADD: begin
          chain[0] <= chain[0] + vars.a;
          chain[1] <= chain[1] + vars.b;
          chain[2] <= chain[2] + vars.c;
          chain[3] <= chain[3] + vars.d;
          chain[4] <= chain[4] + vars.e;
          unique case (after)
            A_GATHER: state <= S_GATHER;
            A_PAD:    state <= S_PAD;
            A_OUT: begin
              state        <= S_OUT;
              result_valid <= 1'b1;
              word_index   <= '0;
              last_word    <= 1'b0;
              digest_word  <= chain[0] + vars.a;
            end
            default:  state <= S_GATHER;
          endcase
        end
        S_OUT: begin
          if (result_valid && !result_stall) begin
            if (last_word) begin
              result_valid <= 1'b0;
              count        <= '0;
              state        <= S_GATHER;
              for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
                chain[i] <= sha1md_pkg::H_INIT[i];
              end
            end else begin
              word_index  <= word_index + 1'b1;
              digest_word <= chain[word_index + 1'b1];
              last_word   <= (word_index == sha1md_pkg::INDEX_W'(sha1md_pkg::DIGEST_WORDS - 2));
            end
          end
        end
        default: state <= S_GATHER;
      endcase
    end
  end

  // No input beat is taken while digest words are still on offer.
  assert property (@(posedge clk) disable iff (rst) result_valid |-> item_stall)
    else $error("input accepted while digest words are pending");

  // The final word of a digest carries index four, and only that one does.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last_word == (word_index == 3'd4)))
    else $error("last_word flag does not match word_index");

  // Taking the last word ends the run: no further result beat follows at once.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && last_word) |=> !result_valid)
    else $error("result beat after the last digest word");

  // The round counter stays inside the 80 rounds of a compression.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (round <= sha1md_pkg::ROUND_LAST))
    else $error("round counter beyond the last round");

endmodule

// ===== sv/sha1md_round.sv =====
// One SHA-1 compression round: round function, constant select and the five-way add.
module sha1md_round (
  input  sha1md_pkg::vars_t  vars,
  input  sha1md_pkg::word_t  sched_word,
  input  sha1md_pkg::round_t round_index,
  output sha1md_pkg::vars_t  advanced
);

  sha1md_pkg::word_t f;
  sha1md_pkg::word_t k;
  sha1md_pkg::word_t t;

  always_comb begin
    priority if (round_index < sha1md_pkg::PHASE1_START) begin
      f = (vars.b & vars.c) | (~vars.b & vars.d);
      k = sha1md_pkg::K_PHASE0;
    end else if (round_index < sha1md_pkg::PHASE2_START) begin
      f = vars.b ^ vars.c ^ vars.d;
      k = sha1md_pkg::K_PHASE1;
    end else if (round_index < sha1md_pkg::PHASE3_START) begin
      f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
      k = sha1md_pkg::K_PHASE2;
    end else begin
      f = vars.b ^ vars.c ^ vars.d;
      k = sha1md_pkg::K_PHASE3;
    end
  end

  assign t = sha1md_pkg::rotl(vars.a, 5) + f + vars.e + k + sched_word;

  assign advanced = '{
    a: t,
    b: vars.a,
    c: sha1md_pkg::rotl(vars.b, 30),
    d: vars.c,
    e: vars.d
  };

endmodule
